/* hdl/nbgu_pkg.sv */
// ----------------------------------------------------------------------------
// nbgu_pkg
// Shared types, constants and helpers for the body update engine.
// ----------------------------------------------------------------------------
package nbgu_pkg;

  localparam int WORD_W = 48;
  localparam int CFG_W  = 47;
  localparam int MASS_W = 32;
  localparam int OP_W   = 64;
  localparam int WIDE_W = 128;
  localparam int RT_W   = 66;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  localparam logic [1:0] CFG_GRAVITY = 2'd0;
  localparam logic [1:0] CFG_STEP    = 2'd1;
  localparam logic [1:0] CFG_BODIES  = 2'd2;

  localparam logic [4:0] BODIES_RESET = 5'd16;

  localparam logic signed [50:0] VMAX51 = 51'sd140737488355327;
  localparam logic signed [50:0] VMIN51 = -51'sd140737488355328;

  typedef enum logic [4:0] {
    S_IDLE, S_RDI, S_LDI, S_PMUL, S_PWR, S_JRD, S_JLD, S_SQ, S_SQRT,
    S_GM, S_UDIV, S_SDIV, S_CMUL, S_CDIV, S_JNEXT, S_VMUL, S_VWR
  } state_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] val;
    logic                     ovf;
  } sat_t;

  function automatic sat_t sat48(input logic signed [50:0] v);
    sat_t r;
    if (v > VMAX51) begin
      r.val = VMAX51[WORD_W-1:0];
      r.ovf = 1'b1;
    end else if (v < VMIN51) begin
      r.val = VMIN51[WORD_W-1:0];
      r.ovf = 1'b1;
    end else begin
      r.val = v[WORD_W-1:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] mag48(input logic signed [WORD_W-1:0] v);
    return v[WORD_W-1] ? WORD_W'(-v) : WORD_W'(v);
  endfunction

  function automatic logic [WORD_W:0] mag49(input logic signed [WORD_W:0] v);
    return v[WORD_W] ? (WORD_W+1)'(-v) : (WORD_W+1)'(v);
  endfunction

endpackage

/* hdl/nbgu_ram.sv */
// ----------------------------------------------------------------------------
// nbgu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nbgu_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/nbgu_mul.sv */
// ----------------------------------------------------------------------------
// nbgu_mul
// 64x64 unsigned multiplier, one 32x32 partial product per cycle.
// ----------------------------------------------------------------------------
module nbgu_mul (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [nbgu_pkg::OP_W-1:0]   a,
  input  logic [nbgu_pkg::OP_W-1:0]   b,
  output logic                        done,
  output logic [nbgu_pkg::WIDE_W-1:0] p
);
  import nbgu_pkg::*;

  logic [OP_W-1:0]   a_r, b_r;
  logic [WIDE_W-1:0] acc;
  logic [1:0]        step;
  logic              run;
  logic [31:0]       a_sel, b_sel;
  logic [63:0]       pp;
  logic [1:0]        sh;

  always_comb begin
    a_sel = step[0] ? a_r[63:32] : a_r[31:0];
    b_sel = step[1] ? b_r[63:32] : b_r[31:0];
    pp    = 64'(a_sel) * 64'(b_sel);
    sh    = {step[0] & step[1], step[0] ^ step[1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      step <= 2'd0;
    end else begin
      done <= run && (step == 2'd3);
      if (start) begin
        run  <= 1'b1;
        step <= 2'd0;
      end else if (run) begin
        step <= step + 2'd1;
        if (step == 2'd3) begin
          run <= 1'b0;
        end
      end
    end
    if (start) begin
      a_r <= a;
      b_r <= b;
      acc <= '0;
    end else if (run) begin
      acc <= acc + (WIDE_W'(pp) << {sh, 5'd0});
    end
  end

  assign p = acc;

endmodule

/* hdl/nbgu_div.sv */
// ----------------------------------------------------------------------------
// nbgu_div
// 128 by 64 bit restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nbgu_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [nbgu_pkg::WIDE_W-1:0] n,
  input  logic [nbgu_pkg::OP_W-1:0]   d,
  output logic                        done,
  output logic [nbgu_pkg::WIDE_W-1:0] q
);
  import nbgu_pkg::*;

  logic [WIDE_W-1:0] nreg;
  logic [OP_W-1:0]   d_r, rem;
  logic [6:0]        cnt;
  logic              run;
  logic [OP_W:0]     remsh;
  logic              ge;

  always_comb begin
    remsh = {rem, nreg[WIDE_W-1]};
    ge    = remsh >= {1'b0, d_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= run && (cnt == 7'd127);
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 7'd1;
        if (cnt == 7'd127) begin
          run <= 1'b0;
        end
      end
    end
    if (start) begin
      nreg <= n;
      d_r  <= d;
      rem  <= '0;
      q    <= '0;
    end else if (run) begin
      nreg <= {nreg[WIDE_W-2:0], 1'b0};
      rem  <= ge ? OP_W'(remsh - {1'b0, d_r}) : remsh[OP_W-1:0];
      q    <= {q[WIDE_W-2:0], ge};
    end
  end

endmodule

/* hdl/nbgu_sqrt.sv */
// ----------------------------------------------------------------------------
// nbgu_sqrt
// 128-bit integer square root, one root bit per cycle (floor).
// ----------------------------------------------------------------------------
module nbgu_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [nbgu_pkg::WIDE_W-1:0] n,
  output logic                        done,
  output logic [nbgu_pkg::OP_W-1:0]   root
);
  import nbgu_pkg::*;

  logic [WIDE_W-1:0] nreg;
  logic [RT_W-1:0]   rem;
  logic [5:0]        cnt;
  logic              run;
  logic [RT_W+1:0]   remsh;
  logic [RT_W+1:0]   trial;
  logic              ge;

  always_comb begin
    remsh = {rem, nreg[WIDE_W-1:WIDE_W-2]};
    trial = (RT_W+2)'({root, 2'b01});
    ge    = remsh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= run && (cnt == 6'd63);
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          run <= 1'b0;
        end
      end
    end
    if (start) begin
      nreg <= n;
      rem  <= '0;
      root <= '0;
    end else if (run) begin
      nreg <= {nreg[WIDE_W-3:0], 2'b00};
      rem  <= ge ? RT_W'(remsh - trial) : remsh[RT_W-1:0];
      root <= {root[OP_W-2:0], ge};
    end
  end

endmodule

/* hdl/nbody_gravity_body_update_top.sv */
// ----------------------------------------------------------------------------
// nbody_gravity_body_update_top
// Table of 2D bodies with per-body load and gravity advance commands.
// ----------------------------------------------------------------------------
// Usage: a command beat is taken when start is high and busy is low. A load
// (command 0) writes one table entry in that cycle and never raises busy;
// its echo appears with done on the next cycle. An advance (command 1)
// raises busy, moves the body by v*dt, sums gravity over entries
// 0..min(bodies_in_use, MAX_BODIES)-1 and updates v; the result appears
// with done for one cycle, and busy falls in that same cycle.
// Advance timing is set by the shared bit-serial 128-bit divider: four
// divisions per table entry in use with a non-coincident position, none for
// a coincident one. The 64-step square root and the shared multiplier add
// to it.
// Configuration: cfg_write with cfg_index and cfg_data, only while idle.
// Reset: sets G and dt to 1.0 and bodies_in_use to 16; table contents are
// undefined until loaded. The receiver cannot stall: done is a strobe.
// ----------------------------------------------------------------------------
module nbody_gravity_body_update_top #(
  parameter int MAX_BODIES = 16,
  parameter int FRAC_BITS  = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  output logic                                done,
  input  logic                                cfg_write,
  input  logic [1:0]                          cfg_index,
  input  logic [nbgu_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                command,
  input  logic [3:0]                          body_index,
  input  logic signed [nbgu_pkg::WORD_W-1:0]  load_x,
  input  logic signed [nbgu_pkg::WORD_W-1:0]  load_y,
  input  logic signed [nbgu_pkg::WORD_W-1:0]  load_vx,
  input  logic signed [nbgu_pkg::WORD_W-1:0]  load_vy,
  input  logic [nbgu_pkg::MASS_W-1:0]         load_mass,
  output logic [3:0]                          result_index,
  output logic signed [nbgu_pkg::WORD_W-1:0]  new_x,
  output logic signed [nbgu_pkg::WORD_W-1:0]  new_y,
  output logic signed [nbgu_pkg::WORD_W-1:0]  new_vx,
  output logic signed [nbgu_pkg::WORD_W-1:0]  new_vy,
  output logic                                saturated
);
  import nbgu_pkg::*;

  localparam int AW    = $clog2(MAX_BODIES);
  localparam int JW    = $clog2(MAX_BODIES + 1);
  localparam int UCLIP = WIDE_W - FRAC_BITS;

  localparam logic [WIDE_W-1:0] U_MAX   = (WIDE_W'(1) << UCLIP) - WIDE_W'(1);
  localparam logic [WIDE_W-1:0] LIM_POS = WIDE_W'(48'h7FFF_FFFF_FFFF);
  localparam logic [WIDE_W-1:0] LIM_NEG = WIDE_W'(48'h8000_0000_0000);
  localparam logic [WIDE_W-1:0] CMP_MAX = WIDE_W'(49'h1_0000_0000_0000);

  state_t state, state_next;

  logic [CFG_W-1:0] grav, tstep;
  logic [4:0]       bodies;

  logic [3:0]               idx;
  logic [3:0]               in_idx;
  logic signed [WORD_W-1:0] pix, piy, vix, viy, ax, ay;
  logic signed [WORD_W:0]   dx, dy;
  logic [MASS_W-1:0]        mj;
  logic [OP_W-1:0]          r, s;
  logic [WIDE_W-1:0]        wreg, r2;
  logic [JW-1:0]            j, nb;
  logic                     comp, issued, sat_flag;

  logic [AW-1:0]     idx_addr, in_addr, rd_addr, wr_addr;
  logic              load_acc;
  logic              pos_we, vel_we;
  logic [WORD_W-1:0] px_q, py_q, vx_q, vy_q;
  logic [MASS_W-1:0] m_q;

  logic                mul_start, div_start, sqrt_start;
  logic                mul_done, div_done, sqrt_done;
  logic [OP_W-1:0]     mul_a, mul_b;
  logic [WIDE_W-1:0]   mul_p, div_n, div_q;
  logic [OP_W-1:0]     sqrt_root;

  logic signed [WORD_W-1:0] mq_src, mq_base, mq_val, acc_sel;
  logic [WIDE_W-1:0]        mq_sh;
  logic                     mq_neg, mq_ovf;
  logic [WORD_W-1:0]        mq_mag;
  sat_t                     mq_sum, c_sum;
  logic signed [WORD_W:0]   d_sel, dx_w, dy_w;
  logic                     jd_zero;
  logic [WORD_W:0]          cmag;
  logic signed [WORD_W+1:0] cval;
  logic [JW:0]              j_inc;

  always_comb begin
    in_idx = '0;
    for (int k = 0; k < 16; k++) begin
      if (body_index == 4'(k)) begin
        in_idx = 4'(k % MAX_BODIES);
      end
    end
  end

  assign in_addr  = AW'(in_idx);
  assign idx_addr = AW'(idx);
  assign load_acc = start && !busy && (command == CMD_LOAD);
  assign busy     = (state != S_IDLE);
  assign nb       = (8'(bodies) > 8'(MAX_BODIES)) ? JW'(MAX_BODIES) : JW'(bodies);
  assign j_inc    = (JW+1)'(j) + (JW+1)'(1);

  // table access
  assign rd_addr = (state == S_RDI) ? idx_addr : j[AW-1:0];
  assign wr_addr = (state == S_IDLE) ? in_addr : idx_addr;
  assign pos_we  = load_acc || (state == S_PWR);
  assign vel_we  = load_acc || (state == S_VWR);

  nbgu_ram #(.WIDTH(WORD_W), .DEPTH(MAX_BODIES)) u_px (
    .clk(clk), .we(pos_we), .waddr(wr_addr),
    .wdata((state == S_IDLE) ? load_x : pix), .raddr(rd_addr), .rdata(px_q));
  nbgu_ram #(.WIDTH(WORD_W), .DEPTH(MAX_BODIES)) u_py (
    .clk(clk), .we(pos_we), .waddr(wr_addr),
    .wdata((state == S_IDLE) ? load_y : piy), .raddr(rd_addr), .rdata(py_q));
  nbgu_ram #(.WIDTH(WORD_W), .DEPTH(MAX_BODIES)) u_vx (
    .clk(clk), .we(vel_we), .waddr(wr_addr),
    .wdata((state == S_IDLE) ? load_vx : vix), .raddr(idx_addr), .rdata(vx_q));
  nbgu_ram #(.WIDTH(WORD_W), .DEPTH(MAX_BODIES)) u_vy (
    .clk(clk), .we(vel_we), .waddr(wr_addr),
    .wdata((state == S_IDLE) ? load_vy : viy), .raddr(idx_addr), .rdata(vy_q));
  nbgu_ram #(.WIDTH(MASS_W), .DEPTH(MAX_BODIES)) u_m (
    .clk(clk), .we(load_acc), .waddr(in_addr),
    .wdata(load_mass), .raddr(j[AW-1:0]), .rdata(m_q));

  // arithmetic units
  nbgu_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .p(mul_p));
  nbgu_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .n(div_n), .d(r),
    .done(div_done), .q(div_q));
  nbgu_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sqrt_start), .n(r2),
    .done(sqrt_done), .root(sqrt_root));

  // operand selection and result shaping
  always_comb begin
    d_sel   = comp ? dy : dx;
    acc_sel = comp ? ay : ax;
    if (state == S_VMUL) begin
      mq_src  = acc_sel;
      mq_base = comp ? viy : vix;
    end else begin
      mq_src  = comp ? viy : vix;
      mq_base = comp ? piy : pix;
    end
    mq_neg = mq_src[WORD_W-1];
    mq_sh  = mul_p >> FRAC_BITS;
    mq_ovf = mq_sh > (mq_neg ? LIM_NEG : LIM_POS);
    mq_mag = mq_ovf ? (mq_neg ? LIM_NEG[WORD_W-1:0] : LIM_POS[WORD_W-1:0])
                    : mq_sh[WORD_W-1:0];
    mq_val = mq_neg ? WORD_W'(-$signed(mq_mag)) : $signed(mq_mag);
    mq_sum = sat48(51'(mq_base) + 51'(mq_val));

    cmag   = (div_q > CMP_MAX) ? CMP_MAX[WORD_W:0] : div_q[WORD_W:0];
    cval   = d_sel[WORD_W] ? -$signed({1'b0, cmag}) : $signed({1'b0, cmag});
    c_sum  = sat48(51'(acc_sel) + 51'(cval));

    dx_w    = $signed({px_q[WORD_W-1], px_q}) - $signed({pix[WORD_W-1], pix});
    dy_w    = $signed({py_q[WORD_W-1], py_q}) - $signed({piy[WORD_W-1], piy});
    jd_zero = (dx_w == '0) && (dy_w == '0);

    div_n = (state == S_CDIV) ? wreg : (wreg << FRAC_BITS);

    unique case (state)
      S_SQ: begin
        mul_a = OP_W'(mag49(d_sel));
        mul_b = OP_W'(mag49(d_sel));
      end
      S_GM: begin
        mul_a = OP_W'(grav);
        mul_b = OP_W'(mj);
      end
      S_CMUL: begin
        mul_a = s;
        mul_b = OP_W'(mag49(d_sel));
      end
      default: begin
        mul_a = OP_W'(mag48(mq_src));
        mul_b = OP_W'(tstep);
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start && (command == CMD_ADVANCE)) state_next = S_RDI;
      end
      S_RDI:  state_next = S_LDI;
      S_LDI:  state_next = S_PMUL;
      S_PMUL: begin
        mul_start = !issued;
        if (mul_done && comp) state_next = S_PWR;
      end
      S_PWR:  state_next = (nb == '0) ? S_VMUL : S_JRD;
      S_JRD:  state_next = S_JLD;
      S_JLD:  state_next = jd_zero ? S_JNEXT : S_SQ;
      S_SQ: begin
        mul_start = !issued;
        if (mul_done && comp) state_next = S_SQRT;
      end
      S_SQRT: begin
        sqrt_start = !issued;
        if (sqrt_done) state_next = S_GM;
      end
      S_GM: begin
        mul_start = !issued;
        if (mul_done) state_next = S_UDIV;
      end
      S_UDIV: begin
        div_start = !issued;
        if (div_done) state_next = S_SDIV;
      end
      S_SDIV: begin
        div_start = !issued;
        if (div_done) state_next = S_CMUL;
      end
      S_CMUL: begin
        mul_start = !issued;
        if (mul_done) state_next = S_CDIV;
      end
      S_CDIV: begin
        div_start = !issued;
        if (div_done) state_next = comp ? S_JNEXT : S_CMUL;
      end
      S_JNEXT: state_next = (j_inc < (JW+1)'(nb)) ? S_JRD : S_VMUL;
      S_VMUL: begin
        mul_start = !issued;
        if (mul_done && comp) state_next = S_VWR;
      end
      S_VWR:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grav     <= CFG_W'(64'd1 << FRAC_BITS);
      tstep    <= CFG_W'(64'd1 << FRAC_BITS);
      bodies   <= BODIES_RESET;
      done     <= 1'b0;
      issued   <= 1'b0;
      comp     <= 1'b0;
      j        <= '0;
      sat_flag <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_GRAVITY: grav   <= cfg_data;
          CFG_STEP:    tstep  <= cfg_data;
          CFG_BODIES:  bodies <= cfg_data[4:0];
          default: ;
        endcase
      end
      done <= load_acc || (state == S_VWR);
      if (mul_start || div_start || sqrt_start) begin
        issued <= 1'b1;
      end else if (mul_done || div_done || sqrt_done) begin
        issued <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          comp     <= 1'b0;
          sat_flag <= 1'b0;
        end
        S_PMUL, S_SQ, S_VMUL: begin
          if (mul_done) comp <= !comp;
          if (mul_done && (state != S_SQ)) sat_flag <= sat_flag | mq_ovf | mq_sum.ovf;
        end
        S_PWR:   j <= '0;
        S_UDIV:  if (div_done && ((div_q >> UCLIP) != '0)) sat_flag <= 1'b1;
        S_SDIV:  if (div_done && (div_q[WIDE_W-1:OP_W] != '0)) sat_flag <= 1'b1;
        S_CDIV: begin
          if (div_done) begin
            comp     <= !comp;
            sat_flag <= sat_flag | c_sum.ovf;
          end
        end
        S_JNEXT: j <= j_inc[JW-1:0];
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        idx <= in_idx;
        if (load_acc) begin
          result_index <= in_idx;
          new_x        <= load_x;
          new_y        <= load_y;
          new_vx       <= load_vx;
          new_vy       <= load_vy;
          saturated    <= 1'b0;
        end
      end
      S_LDI: begin
        pix <= px_q;
        piy <= py_q;
        vix <= vx_q;
        viy <= vy_q;
      end
      S_PMUL: begin
        if (mul_done) begin
          if (comp) piy <= mq_sum.val;
          else      pix <= mq_sum.val;
        end
      end
      S_PWR: begin
        ax <= '0;
        ay <= '0;
      end
      S_JLD: begin
        dx <= dx_w;
        dy <= dy_w;
        mj <= m_q;
      end
      S_SQ: begin
        if (mul_done) r2 <= comp ? (r2 + mul_p) : mul_p;
      end
      S_SQRT: if (sqrt_done) r <= sqrt_root;
      S_GM:   if (mul_done) wreg <= mul_p;
      S_UDIV: if (div_done) wreg <= ((div_q >> UCLIP) != '0) ? U_MAX : div_q;
      S_SDIV: begin
        if (div_done) s <= (div_q[WIDE_W-1:OP_W] != '0) ? '1 : div_q[OP_W-1:0];
      end
      S_CMUL: if (mul_done) wreg <= mul_p;
      S_CDIV: begin
        if (div_done) begin
          if (comp) ay <= c_sum.val;
          else      ax <= c_sum.val;
        end
      end
      S_VMUL: begin
        if (mul_done) begin
          if (comp) viy <= mq_sum.val;
          else      vix <= mq_sum.val;
        end
      end
      S_VWR: begin
        result_index <= idx;
        new_x        <= pix;
        new_y        <= piy;
        new_vx       <= vix;
        new_vy       <= viy;
        saturated    <= sat_flag;
      end
      default: ;
    endcase
  end

endmodule
